// ===== hdl/lif_pkg.sv =====
// Shared types and constants for the leaky integrate-and-fire neuron step.
package lif_pkg;

  typedef struct packed {
    logic signed [31:0] synaptic_current;
    logic signed [31:0] external_current;
  } lif_in_t;

  typedef struct packed {
    logic               spike;
    logic signed [15:0] membrane_potential;
    logic               in_refractory;
  } lif_out_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_LEAK_GAIN      = 3'd0;
  localparam logic [2:0] CFG_DRIVE_GAIN     = 3'd1;
  localparam logic [2:0] CFG_REST_POTENTIAL = 3'd2;
  localparam logic [2:0] CFG_RESET_POTENTIAL = 3'd3;
  localparam logic [2:0] CFG_THRESHOLD      = 3'd4;
  localparam logic [2:0] CFG_REFRACTORY     = 3'd5;
  localparam logic [2:0] CFG_TIMESTEP       = 3'd6;

  // Configuration reset values
  localparam logic [15:0]        LEAK_GAIN_RST  = 16'd3277;
  localparam logic [31:0]        DRIVE_GAIN_RST = 32'd32768000;
  localparam logic signed [15:0] REST_RST       = -16'sd17920;
  localparam logic signed [15:0] VRESET_RST     = -16'sd16640;
  localparam logic signed [15:0] THRESHOLD_RST  = -16'sd12800;
  localparam logic [15:0]        REFRACTORY_RST = 16'd512;
  localparam logic [15:0]        TIMESTEP_RST   = 16'd256;

  // 10 nA in Q16.16 and 0.95 in Q0.16
  localparam logic [31:0] ADAPT_STEP = 32'd655360;
  localparam logic [15:0] DECAY_Q16  = 16'd62259;

endpackage

// ===== hdl/lif_neuron_step.sv =====
// Top level: one LIF neuron tick per input transaction, with configuration registers.
// An accepted input transaction reaches out_valid through the input register, then
//   the result register.
// One transaction per cycle while out_stall does not hold the result register; the neuron state
//   updates in the same cycle that a registered input moves into the result register.
// Reset (rst_n low, synchronous): pipeline empties, configuration returns to its
//   defaults, potential goes to -70 mV, refractory timer and adaptation to zero.
module lif_neuron_step
  import lif_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  lif_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output lif_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic signed [33:0] I_MAX = 34'sd2147483647;
  localparam logic signed [33:0] I_MIN = -34'sd2147483648;
  localparam logic signed [42:0] V_MAX = 43'sd32767;
  localparam logic signed [42:0] V_MIN = -43'sd32768;
  localparam logic [30:0]        A_MAX = 31'h7FFF_FFFF;

  // configuration
  logic [15:0]        leak_gain_r;
  logic [31:0]        drive_gain_r;
  logic signed [15:0] rest_r;
  logic signed [15:0] vreset_r;
  logic signed [15:0] threshold_r;
  logic [15:0]        refractory_r;
  logic [15:0]        timestep_r;

  // neuron state; adaptation is never negative
  logic signed [15:0] pot_r;
  logic [15:0]        refr_left_r;
  logic [30:0]        adapt_r;

  // pipeline
  logic     in_valid_r;
  lif_in_t  in_data_r;
  logic     out_valid_r;
  lif_out_t out_data_r;

  logic in_accept;
  logic advance;

  // datapath
  logic signed [33:0] sum_cur;
  logic signed [31:0] itot;
  logic signed [64:0] drive_prod;
  logic signed [40:0] drive;
  logic signed [16:0] vdiff;
  logic signed [33:0] leak_prod;
  logic signed [17:0] leak;
  logic signed [42:0] vsum;
  logic signed [15:0] vnew;
  logic               fire;
  logic [31:0]        adapt_inc;
  logic [30:0]        adapt_sat;
  logic [46:0]        decay_keep;
  logic [46:0]        decay_fire;
  logic [15:0]        refr_dec;
  logic               refractory;

  logic signed [15:0] pot_nxt;
  logic [15:0]        refr_left_nxt;
  logic [30:0]        adapt_nxt;
  lif_out_t           out_data_nxt;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    refractory = (refr_left_r != 16'd0);

    sum_cur = {{2{in_data_r.synaptic_current[31]}}, in_data_r.synaptic_current}
            + {{2{in_data_r.external_current[31]}}, in_data_r.external_current}
            + $signed({3'b000, adapt_r});
    if (sum_cur > I_MAX) begin
      itot = I_MAX[31:0];
    end else if (sum_cur < I_MIN) begin
      itot = I_MIN[31:0];
    end else begin
      itot = sum_cur[31:0];
    end

    // arithmetic shifts give floor rounding
    drive_prod = 65'($signed({1'b0, drive_gain_r})) * 65'(itot);
    drive      = drive_prod[64:24];
    vdiff      = {pot_r[15], pot_r} - {rest_r[15], rest_r};
    leak_prod  = 34'($signed({1'b0, leak_gain_r})) * 34'(vdiff);
    leak       = leak_prod[33:16];

    vsum = {{27{pot_r[15]}}, pot_r} + {{2{drive[40]}}, drive} - {{25{leak[17]}}, leak};
    if (vsum > V_MAX) begin
      vnew = V_MAX[15:0];
    end else if (vsum < V_MIN) begin
      vnew = V_MIN[15:0];
    end else begin
      vnew = vsum[15:0];
    end
    fire = (vnew >= threshold_r);

    // both adaptation candidates decay in parallel with the drive product
    adapt_inc  = {1'b0, adapt_r} + ADAPT_STEP;
    adapt_sat  = adapt_inc[31] ? A_MAX : adapt_inc[30:0];
    decay_keep = 47'(adapt_r) * 47'(DECAY_Q16);
    decay_fire = 47'(adapt_sat) * 47'(DECAY_Q16);

    refr_dec = (refr_left_r > timestep_r) ? (refr_left_r - timestep_r) : 16'd0;

    if (refractory) begin
      pot_nxt       = vreset_r;
      refr_left_nxt = refr_dec;
      adapt_nxt     = adapt_r;
    end else if (fire) begin
      pot_nxt       = vreset_r;
      refr_left_nxt = refractory_r;
      adapt_nxt     = decay_fire[46:16];
    end else begin
      pot_nxt       = vnew;
      refr_left_nxt = 16'd0;
      adapt_nxt     = decay_keep[46:16];
    end

    out_data_nxt.spike              = !refractory && fire;
    out_data_nxt.membrane_potential = pot_nxt;
    out_data_nxt.in_refractory      = refractory;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_gain_r  <= LEAK_GAIN_RST;
      drive_gain_r <= DRIVE_GAIN_RST;
      rest_r       <= REST_RST;
      vreset_r     <= VRESET_RST;
      threshold_r  <= THRESHOLD_RST;
      refractory_r <= REFRACTORY_RST;
      timestep_r   <= TIMESTEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEAK_GAIN:       leak_gain_r  <= cfg_data[15:0];
        CFG_DRIVE_GAIN:      drive_gain_r <= cfg_data;
        CFG_REST_POTENTIAL:  rest_r       <= cfg_data[15:0];
        CFG_RESET_POTENTIAL: vreset_r     <= cfg_data[15:0];
        CFG_THRESHOLD:       threshold_r  <= cfg_data[15:0];
        CFG_REFRACTORY:      refractory_r <= cfg_data[15:0];
        CFG_TIMESTEP:        timestep_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pot_r       <= REST_RST;
      refr_left_r <= 16'd0;
      adapt_r     <= 31'd0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end

      if (advance) begin
        pot_r       <= pot_nxt;
        refr_left_r <= refr_left_nxt;
        adapt_r     <= adapt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== hdl/lif_neuron_step_chk.sv =====
// Port-level checker for lif_neuron_step and its bind.
module lif_neuron_step_chk
  import lif_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input lif_out_t out_data
);

  // pipeline comes up empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // input side only backs up when the result register is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result path is free");

  // a refractory tick never fires
  a_refr_no_spike: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.spike && out_data.in_refractory))
    else $error("spike reported on a refractory tick");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

endmodule

bind lif_neuron_step lif_neuron_step_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== bench/lif_checker.sv =====
// Scoreboard for the LIF neuron step: tracks neuron state, predicts each tick and checks results.
module lif_checker
  import lif_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  lif_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  lif_out_t    out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CURRENT_MAX = 64'sd2147483647;
  localparam longint CURRENT_MIN = -64'sd2147483648;

  // configuration copy
  logic [15:0]        leak_cfg;
  logic [31:0]        drive_cfg;
  logic signed [15:0] rest_cfg;
  logic signed [15:0] vreset_cfg;
  logic signed [15:0] vth_cfg;
  logic [15:0]        refr_cfg;
  logic [15:0]        dt_cfg;

  // neuron state
  logic signed [15:0] mem_v;
  logic [15:0]        refr_left;
  logic [31:0]        adapt_cur;

  lif_out_t expected_ticks[$];
  int       errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic lif_out_t neuron_tick(input lif_in_t tick);
    longint   i_sum;
    longint   drive;
    longint   leak;
    longint   v_next;
    longint   a_next;
    lif_out_t r;
    r = '0;
    if (refr_left != 16'd0) begin
      mem_v = vreset_cfg;
      refr_left = (refr_left > dt_cfg) ? refr_left - dt_cfg : 16'd0;
      r.in_refractory = 1'b1;
    end else begin
      i_sum = longint'(tick.synaptic_current) + longint'(tick.external_current)
            + longint'(adapt_cur);
      if (i_sum > CURRENT_MAX) i_sum = CURRENT_MAX;
      if (i_sum < CURRENT_MIN) i_sum = CURRENT_MIN;
      // arithmetic shifts give floor rounding
      drive  = (longint'(drive_cfg) * i_sum) >>> 24;
      leak   = (longint'(leak_cfg) * (longint'(mem_v) - longint'(rest_cfg))) >>> 16;
      v_next = longint'(mem_v) + drive - leak;
      if (v_next > 64'sd32767)  v_next = 64'sd32767;
      if (v_next < -64'sd32768) v_next = -64'sd32768;
      a_next = longint'(adapt_cur);
      if (v_next >= longint'(vth_cfg)) begin
        r.spike   = 1'b1;
        a_next    = a_next + longint'(ADAPT_STEP);
        if (a_next > CURRENT_MAX) a_next = CURRENT_MAX;
        refr_left = refr_cfg;
        mem_v     = vreset_cfg;
      end else begin
        mem_v = 16'(v_next);
      end
      // adaptation is never negative, so a plain shift truncates toward zero
      adapt_cur = 32'((a_next * longint'(DECAY_Q16)) >> 16);
    end
    r.membrane_potential = mem_v;
    return r;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    lif_out_t want;
    if (!rst_n) begin
      leak_cfg   = LEAK_GAIN_RST;
      drive_cfg  = DRIVE_GAIN_RST;
      rest_cfg   = REST_RST;
      vreset_cfg = VRESET_RST;
      vth_cfg    = THRESHOLD_RST;
      refr_cfg   = REFRACTORY_RST;
      dt_cfg     = TIMESTEP_RST;
      mem_v      = REST_RST;
      refr_left  = 16'd0;
      adapt_cur  = 32'd0;
      expected_ticks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEAK_GAIN:       leak_cfg   = cfg_data[15:0];
          CFG_DRIVE_GAIN:      drive_cfg  = cfg_data;
          CFG_REST_POTENTIAL:  rest_cfg   = cfg_data[15:0];
          CFG_RESET_POTENTIAL: vreset_cfg = cfg_data[15:0];
          CFG_THRESHOLD:       vth_cfg    = cfg_data[15:0];
          CFG_REFRACTORY:      refr_cfg   = cfg_data[15:0];
          CFG_TIMESTEP:        dt_cfg     = cfg_data[15:0];
          default: ;
        endcase
      end
      // check before pushing: a tick accepted now cannot have its result yet
      if (out_valid && !out_stall) begin
        if (expected_ticks.size() == 0) begin
          errors++;
          $error("result transaction with no tick outstanding");
        end else begin
          want = expected_ticks.pop_front();
          compare_field("spike", want.spike, out_data.spike);
          compare_field("membrane_potential", want.membrane_potential,
                        out_data.membrane_potential);
          compare_field("in_refractory", want.in_refractory, out_data.in_refractory);
        end
      end
      if (in_valid && !in_stall)
        expected_ticks.push_back(neuron_tick(in_data));
    end
    pending    <= expected_ticks.size();
    fail_count <= errors;
  end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for lif_neuron_step: clock, reset, tick and register stimulus, verdict.
module tb_top
  import lif_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]         CFG_UNUSED      = 3'd7;
  localparam logic signed [31:0] I_MAX           = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] I_MIN           = 32'sh8000_0000;
  localparam int                 NUM_PHASES      = 12;
  localparam int                 ITEMS_PER_PHASE = 154;
  localparam int                 IDLE_PCT        = 14;
  localparam int                 LIMIT_CYCLES    = 200000;

  typedef struct packed {
    logic [15:0]        leak;
    logic [31:0]        drive;
    logic signed [15:0] rest;
    logic signed [15:0] vreset;
    logic signed [15:0] vth;
    logic [15:0]        refr;
    logic [15:0]        dt;
  } neuron_cfg_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  lif_in_t     in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  lif_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;
  bit          calm = 1'b0;
  int          cycle_count = 0;

  lif_neuron_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lif_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic neuron_cfg_t make_config(
    input logic [15:0] leak, input logic [31:0] drive,
    input logic signed [15:0] rest, input logic signed [15:0] vreset,
    input logic signed [15:0] vth, input logic [15:0] refr, input logic [15:0] dt);
    neuron_cfg_t c;
    c.leak   = leak;
    c.drive  = drive;
    c.rest   = rest;
    c.vreset = vreset;
    c.vth    = vth;
    c.refr   = refr;
    c.dt     = dt;
    return c;
  endfunction

  function automatic neuron_cfg_t rand_config();
    neuron_cfg_t c;
    if ($urandom_range(0, 3) == 0) begin
      c = {$urandom(), $urandom(), $urandom(), $urandom()};
    end else begin
      c.leak   = 16'($urandom_range(0, 16384));
      c.drive  = $urandom_range(0, 4 * 65536);
      c.rest   = 16'(-17920 + int'($urandom_range(0, 4000)) - 2000);
      c.vreset = c.rest + 16'($urandom_range(0, 2000));
      c.vth    = c.rest + 16'($urandom_range(500, 8000));
      c.refr   = 16'($urandom_range(0, 1536));
      c.dt     = 16'($urandom_range(64, 512));
    end
    return c;
  endfunction

  // currents in nA Q16.16, mostly in a range where the neuron integrates and fires
  function automatic logic signed [31:0] rand_current();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      return 32'($urandom_range(0, 8192)) - 32'd4096;
    else if (pick < 70) return 32'($urandom_range(0, 1 << 19)) - 32'd131072;
    else if (pick < 85) return $urandom();
    else if (pick < 92) begin
      case ($urandom_range(0, 4))
        0:       return I_MAX;
        1:       return I_MIN;
        2:       return 32'sd1;
        3:       return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return 32'sd0;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // upper data bits are junk on purpose: 16-bit registers must ignore them
  task automatic load_config(input neuron_cfg_t c);
    write_reg(CFG_LEAK_GAIN,       {16'($urandom()), c.leak});
    write_reg(CFG_DRIVE_GAIN,      c.drive);
    write_reg(CFG_REST_POTENTIAL,  {16'($urandom()), c.rest});
    write_reg(CFG_RESET_POTENTIAL, {16'($urandom()), c.vreset});
    write_reg(CFG_THRESHOLD,       {16'($urandom()), c.vth});
    write_reg(CFG_REFRACTORY,      {16'($urandom()), c.refr});
    write_reg(CFG_TIMESTEP,        {16'($urandom()), c.dt});
    write_reg(CFG_UNUSED,          $urandom());
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input logic signed [31:0] syn, input logic signed [31:0] ext);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.synaptic_current <= syn;
    in_data.external_current <= ext;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off new ticks until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    neuron_cfg_t       cfg;
    logic signed [31:0] base_syn;
    int                burst_left;
    base_syn   = 32'sd0;
    burst_left = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_LEAK_GAIN;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset: saturation of the current sum, spike then refractory ticks
    send_tick(32'sd0, 32'sd0);
    send_tick(I_MAX, I_MAX);
    send_tick(32'sd0, 32'sd0);
    send_tick(32'sd0, 32'sd0);
    send_tick(I_MIN, I_MIN);
    send_tick(I_MIN, 32'sd0);
    send_tick(I_MAX, I_MIN);
    send_tick(32'sd1, -32'sd1);
    send_tick(32'sd4096, 32'sd0);
    send_tick(-32'sd4096, -32'sd4096);

    // largest gains and threshold, zero refractory period
    drain();
    load_config(make_config(16'hFFFF, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                            16'd0, 16'hFFFF));
    send_tick(I_MAX, I_MAX);
    send_tick(32'sd0, 32'sd0);
    send_tick(I_MIN, I_MIN);
    send_tick(I_MAX, 32'sd0);
    send_tick(-32'sd1, -32'sd1);
    send_tick(32'sd1, 32'sd0);

    // zero gains, lowest threshold: fires on every integrating tick
    drain();
    load_config(make_config(16'd0, 32'd0, 16'sh8000, 16'sh7FFF, 16'sh8000,
                            16'hFFFF, 16'hFFFF));
    send_tick(32'sd0, 32'sd0);
    send_tick(I_MAX, I_MAX);
    send_tick(32'sd0, 32'sd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      calm = (p == 0);
      case (p)
        0: cfg = make_config(16'd3277, 32'd65536, -16'sd17920, -16'sd16640, -16'sd12800,
                             16'd512, 16'd256);
        1: cfg = make_config(16'hFFFF, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                             16'd0, 16'hFFFF);
        2: cfg = make_config(16'd0, 32'd0, 16'sh8000, 16'sh7FFF, 16'sh8000,
                             16'hFFFF, 16'hFFFF);
        3: cfg = make_config(16'd6554, 32'd131072, -16'sd17920, -16'sd17000, -16'sd14000,
                             16'd0, 16'd0);
        default: cfg = rand_config();
      endcase
      load_config(cfg);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // bursts of steady drive so the neuron charges up, fires and recovers
        if (burst_left == 0) begin
          base_syn   = rand_current();
          burst_left = $urandom_range(10, 60);
        end
        burst_left--;
        if ($urandom_range(0, 9) == 0)
          send_tick($urandom(), $urandom());
        else
          send_tick(base_syn + 32'($urandom_range(0, 2048)) - 32'sd1024,
                    ($urandom_range(0, 1) == 0) ? rand_current()
                                                : 32'($urandom_range(0, 512)) - 32'sd256);
        if ($urandom_range(0, 99) == 0)
          drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
